// ----- rtl/core/dotp_pkg.sv -----
// Package for the DHCP option TLV parser: event codes, walk phases and option
// classification. It has no dependencies. The output interface and the top level use it.
`default_nettype none

package dotp_pkg;

    localparam int VALUE_W = 48;

    typedef enum logic [3:0] {
        EV_MASK    = 4'd0,
        EV_ROUTER  = 4'd1,
        EV_DNS     = 4'd2,
        EV_BCAST   = 4'd3,
        EV_REQ_IP  = 4'd4,
        EV_SERV_IP = 4'd5,
        EV_LEASE   = 4'd6,
        EV_RENEW   = 4'd7,
        EV_REBIND  = 4'd8,
        EV_MSGTYPE = 4'd9,
        EV_MAC     = 4'd10,
        EV_HOST    = 4'd11,
        EV_DOMAIN  = 4'd12,
        EV_VENDOR  = 4'd13,
        EV_DONE    = 4'd14,
        EV_ERROR   = 4'd15
    } evt_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_CODE    = 3'd1,
        PH_LEN     = 3'd2,
        PH_VALUE   = 3'd3,
        PH_MSG     = 3'd4,
        PH_MACTYPE = 3'd5,
        PH_STR     = 3'd6,
        PH_SKIP    = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        KIND_SKIP  = 3'd0,
        KIND_FIXED = 3'd1,
        KIND_MSG   = 3'd2,
        KIND_MAC   = 3'd3,
        KIND_STR   = 3'd4,
        KIND_END   = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t kind;
        evt_t  evt;
    } opt_class_t;

    localparam logic [7:0] OPT_MASK    = 8'd1;
    localparam logic [7:0] OPT_ROUTER  = 8'd3;
    localparam logic [7:0] OPT_DNS     = 8'd6;
    localparam logic [7:0] OPT_HOST    = 8'd12;
    localparam logic [7:0] OPT_DOMAIN  = 8'd15;
    localparam logic [7:0] OPT_BCAST   = 8'd28;
    localparam logic [7:0] OPT_REQ_IP  = 8'd50;
    localparam logic [7:0] OPT_LEASE   = 8'd51;
    localparam logic [7:0] OPT_MSGTYPE = 8'd53;
    localparam logic [7:0] OPT_SERV_IP = 8'd54;
    localparam logic [7:0] OPT_RENEW   = 8'd58;
    localparam logic [7:0] OPT_REBIND  = 8'd59;
    localparam logic [7:0] OPT_VENDOR  = 8'd60;
    localparam logic [7:0] OPT_CLID    = 8'd61;
    localparam logic [7:0] OPT_END     = 8'hFF;

    // Required length of the fixed options, of the client id option, and its
    // expected hardware type.
    localparam logic [7:0] FIXED_LEN    = 8'd4;
    localparam int         CLID_LEN     = 7;
    localparam logic [7:0] CLID_HW_TYPE = 8'd1;

    // Fewest bytes left in the area that still let a new option begin.
    localparam int MIN_REMAIN = 3;

    function automatic opt_class_t dotp_classify(input logic [7:0] code);
        opt_class_t c;
        c.kind = KIND_SKIP;
        c.evt  = EV_MASK;
        unique case (code)
            OPT_MASK:    begin c.kind = KIND_FIXED; c.evt = EV_MASK;     end
            OPT_ROUTER:  begin c.kind = KIND_FIXED; c.evt = EV_ROUTER;   end
            OPT_DNS:     begin c.kind = KIND_FIXED; c.evt = EV_DNS;      end
            OPT_BCAST:   begin c.kind = KIND_FIXED; c.evt = EV_BCAST;    end
            OPT_REQ_IP:  begin c.kind = KIND_FIXED; c.evt = EV_REQ_IP;   end
            OPT_SERV_IP: begin c.kind = KIND_FIXED; c.evt = EV_SERV_IP;  end
            OPT_LEASE:   begin c.kind = KIND_FIXED; c.evt = EV_LEASE;    end
            OPT_RENEW:   begin c.kind = KIND_FIXED; c.evt = EV_RENEW;    end
            OPT_REBIND:  begin c.kind = KIND_FIXED; c.evt = EV_REBIND;   end
            OPT_MSGTYPE: begin c.kind = KIND_MSG;   c.evt = EV_MSGTYPE;  end
            OPT_CLID:    begin c.kind = KIND_MAC;   c.evt = EV_MAC;      end
            OPT_HOST:    begin c.kind = KIND_STR;   c.evt = EV_HOST;     end
            OPT_DOMAIN:  begin c.kind = KIND_STR;   c.evt = EV_DOMAIN;   end
            OPT_VENDOR:  begin c.kind = KIND_STR;   c.evt = EV_VENDOR;   end
            OPT_END:     begin c.kind = KIND_END;   c.evt = EV_MASK;     end
            default:     begin c.kind = KIND_SKIP;  c.evt = EV_MASK;     end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dotp_opt_if.sv -----
// Input channel of the DHCP option TLV parser: start items and option bytes.
// It depends on nothing else. The area length width is a parameter.
`default_nettype none

interface dotp_opt_if #(
    parameter int AREA_LEN_BITS = 11
);
    logic                     valid;
    logic                     ready;
    logic                     action;
    logic [7:0]               data_byte;
    logic [AREA_LEN_BITS-1:0] area_length;

    modport source (output valid, output action, output data_byte, output area_length,
                    input ready);
    modport sink   (input valid, input action, input data_byte, input area_length,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dotp_evt_if.sv -----
// Output channel of the DHCP option TLV parser: one event per transfer.
// It depends on dotp_pkg for the value width.
`default_nettype none

interface dotp_evt_if;
    logic                         valid;
    logic                         ready;
    logic [3:0]                   event_res;
    logic [dotp_pkg::VALUE_W-1:0] value;
    logic                         string_last;

    modport source (output valid, output event_res, output value, output string_last,
                    input ready);
    modport sink   (input valid, input event_res, input value, input string_last,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dhcp_option_tlv_parser.sv -----
// DHCP options area parser, one byte per transfer.
// It depends on dotp_pkg, dotp_opt_if and dotp_evt_if.
//
// Usage: opt_stream carries either a start item (action 0, with area_length) or
// one option byte (action 1, with data_byte). A start item aborts any walk in
// progress. evt_stream carries the events: decoded addresses, times, message
// type, client MAC, string bytes with string_last on the final one, and a
// closing done or error. Each input transfer gives zero or one event.
//
// The event caused by an item is valid in the cycle after its transfer. The
// parser sustains one item per cycle. The walk state and the single output
// register both update at the same edge, so a new item is accepted while the
// previous event is being taken. When the receiver stalls with an event
// pending, opt_stream.ready drops until that event goes.
//
// Reset leaves the parser idle with no event pending. Option bytes that
// arrive while idle are accepted and dropped.
`default_nettype none

module dhcp_option_tlv_parser #(
    parameter int MAX_OPTION_LEN = 30,
    parameter int AREA_LEN_BITS  = 11
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dotp_opt_if.sink    opt_stream,
    dotp_evt_if.source  evt_stream
);
    import dotp_pkg::*;

    localparam int LEN_W  = $clog2(MAX_OPTION_LEN);
    localparam int NEED_W = ((AREA_LEN_BITS > 9) ? AREA_LEN_BITS : 9) + 1;

    phase_t                   phase_reg,  phase_next;
    logic [7:0]               code_reg,   code_next;
    logic [LEN_W-1:0]         len_reg,    len_next;
    logic [LEN_W-1:0]         seen_reg,   seen_next;
    logic [AREA_LEN_BITS-1:0] remain_reg, remain_next;
    logic [VALUE_W-1:0]       acc_reg,    acc_next;

    logic                     ovalid_reg;
    evt_t                     oevent_reg;
    logic [VALUE_W-1:0]       ovalue_reg;
    logic                     olast_reg;

    logic                     in_fire;
    logic                     res_valid;
    evt_t                     res_event;
    logic [VALUE_W-1:0]       res_value;
    logic                     res_last;

    opt_class_t               cls;
    logic [7:0]               b;
    logic [NEED_W-1:0]        need;
    logic [NEED_W-1:0]        remain_ext;
    logic [AREA_LEN_BITS-1:0] remain_after;
    logic [LEN_W-1:0]         seen_inc;
    logic                     seen_full;

    assign opt_stream.ready = !ovalid_reg || evt_stream.ready;
    assign in_fire          = opt_stream.valid && opt_stream.ready;

    assign b            = opt_stream.data_byte;
    assign cls          = dotp_classify(code_reg);
    assign need         = NEED_W'(b) + NEED_W'(2);
    assign remain_ext   = NEED_W'(remain_reg);
    assign remain_after = (remain_ext >= need) ? AREA_LEN_BITS'(remain_ext - need)
                                               : '0;
    assign seen_inc     = seen_reg + LEN_W'(1);
    assign seen_full    = (seen_inc >= len_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        code_next   = code_reg;
        len_next    = len_reg;
        seen_next   = seen_reg;
        remain_next = remain_reg;
        acc_next    = acc_reg;
        res_valid   = 1'b0;
        res_event   = EV_DONE;
        res_value   = '0;
        res_last    = 1'b0;

        if (!opt_stream.action)
        begin
            code_next   = '0;
            len_next    = '0;
            seen_next   = '0;
            acc_next    = '0;
            remain_next = AREA_LEN_BITS'(opt_stream.area_length);
            if (AREA_LEN_BITS'(opt_stream.area_length) < AREA_LEN_BITS'(MIN_REMAIN))
            begin
                phase_next = PH_IDLE;
                res_valid  = 1'b1;
                res_event  = EV_DONE;
            end
            else
            begin
                phase_next = PH_CODE;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                end
                PH_CODE:
                begin
                    if (remain_reg < AREA_LEN_BITS'(MIN_REMAIN))
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res_event  = EV_DONE;
                    end
                    else
                    begin
                        code_next  = b;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    remain_next = remain_after;
                    if (9'(b) >= 9'(MAX_OPTION_LEN))
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res_event  = EV_ERROR;
                    end
                    else
                    begin
                        len_next  = LEN_W'(b);
                        seen_next = '0;
                        acc_next  = '0;
                        priority if (cls.kind == KIND_END)
                        begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res_event  = EV_DONE;
                        end
                        else if (cls.kind == KIND_FIXED)
                        begin
                            if (b != FIXED_LEN)
                            begin
                                phase_next = PH_IDLE;
                                res_valid  = 1'b1;
                                res_event  = EV_ERROR;
                            end
                            else
                            begin
                                phase_next = PH_VALUE;
                            end
                        end
                        else if (cls.kind == KIND_MAC)
                        begin
                            phase_next = PH_MACTYPE;
                        end
                        else if (b == 8'd0)
                        begin
                            // Empty option: the next header starts right away.
                            if (remain_after < AREA_LEN_BITS'(MIN_REMAIN))
                            begin
                                phase_next = PH_IDLE;
                                res_valid  = 1'b1;
                                res_event  = EV_DONE;
                            end
                            else
                            begin
                                phase_next = PH_CODE;
                            end
                        end
                        else if (cls.kind == KIND_MSG)
                        begin
                            phase_next = PH_MSG;
                        end
                        else if (cls.kind == KIND_STR)
                        begin
                            phase_next = PH_STR;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
                PH_MACTYPE:
                begin
                    if (len_reg != LEN_W'(CLID_LEN) || b != CLID_HW_TYPE)
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res_event  = EV_ERROR;
                    end
                    else
                    begin
                        // The type byte counts as the first value byte.
                        seen_next  = LEN_W'(1);
                        phase_next = PH_VALUE;
                    end
                end
                PH_VALUE:
                begin
                    acc_next  = {acc_reg[VALUE_W-9:0], b};
                    seen_next = seen_inc;
                    if (seen_full)
                    begin
                        phase_next = PH_CODE;
                        res_valid  = 1'b1;
                        res_event  = cls.evt;
                        res_value  = {acc_reg[VALUE_W-9:0], b};
                    end
                end
                PH_MSG:
                begin
                    seen_next  = LEN_W'(1);
                    phase_next = (len_reg > LEN_W'(1)) ? PH_SKIP : PH_CODE;
                    res_valid  = 1'b1;
                    res_event  = EV_MSGTYPE;
                    res_value  = VALUE_W'(b);
                end
                PH_STR:
                begin
                    seen_next = seen_inc;
                    res_valid = 1'b1;
                    res_event = cls.evt;
                    res_value = VALUE_W'(b);
                    res_last  = seen_full;
                    if (seen_full)
                    begin
                        phase_next = PH_CODE;
                    end
                end
                PH_SKIP:
                begin
                    seen_next = seen_inc;
                    if (seen_full)
                    begin
                        if (remain_reg < AREA_LEN_BITS'(MIN_REMAIN))
                        begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res_event  = EV_DONE;
                        end
                        else
                        begin
                            phase_next = PH_CODE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            code_reg   <= '0;
            len_reg    <= '0;
            seen_reg   <= '0;
            remain_reg <= '0;
            acc_reg    <= '0;
        end
        else if (in_fire)
        begin
            phase_reg  <= phase_next;
            code_reg   <= code_next;
            len_reg    <= len_next;
            seen_reg   <= seen_next;
            remain_reg <= remain_next;
            acc_reg    <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (opt_stream.ready)
        begin
            ovalid_reg <= in_fire && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && res_valid)
        begin
            oevent_reg <= res_event;
            ovalue_reg <= res_value;
            olast_reg  <= res_last;
        end
    end

    assign evt_stream.valid       = ovalid_reg;
    assign evt_stream.event_res   = oevent_reg;
    assign evt_stream.value       = ovalue_reg;
    assign evt_stream.string_last = olast_reg;

    // A pending event that is not taken must block further input.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !evt_stream.ready) |-> !opt_stream.ready)
        else $error("input accepted while an event is stalled");

    // Done and error always close the walk.
    a_close_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && res_valid && (res_event == EV_DONE || res_event == EV_ERROR))
            |=> (phase_reg == PH_IDLE))
        else $error("walk still active after done or error");

    // The string end mark only rides on string byte events.
    a_last_on_string: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && olast_reg) |->
            (oevent_reg == EV_HOST || oevent_reg == EV_DOMAIN || oevent_reg == EV_VENDOR))
        else $error("string_last set on a non-string event");

    // While inside an option body the byte count stays below the length.
    a_seen_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_VALUE || phase_reg == PH_STR || phase_reg == PH_SKIP)
            |-> (seen_reg < len_reg))
        else $error("option byte count ran past its length");

endmodule

`default_nettype wire
